FILE: design/x86au_pkg.sv
// x86au_pkg: operation codes and controller/datapath interface types
// for the 16-bit arithmetic unit. No dependencies.
`timescale 1ns / 1ps

package x86au_pkg;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_ADC = 3'd1;
	localparam logic [2:0] OP_SUB = 3'd2;
	localparam logic [2:0] OP_SBB = 3'd3;
	localparam logic [2:0] OP_MUL = 3'd4;
	localparam logic [2:0] OP_DIV = 3'd5;

	localparam int DIV_STEPS = 8;

	typedef struct packed {
		logic load_in;
		logic div_step;
		logic load_out;
	} x86au_cmd_t;

	typedef struct packed {
		logic in_is_div;
	} x86au_stat_t;

endpackage

FILE: design/x86au_dpath.sv
// x86au_dpath: operand registers, add/subtract/multiply logic, byte divider
// and result registers. Depends on x86au_pkg.
`timescale 1ns / 1ps

module x86au_dpath
	import x86au_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  x86au_cmd_t  cmd,
	output x86au_stat_t stat,
	input  logic [2:0]  operation,
	input  logic        word_size,
	input  logic [15:0] operand_a,
	input  logic [15:0] operand_b,
	output logic [15:0] result_low,
	output logic [15:0] result_high,
	output logic        zero_flag,
	output logic        carry_flag,
	output logic        overflow_flag,
	output logic        divide_error
);

	logic [2:0]  op_q;
	logic        word_q;
	logic [15:0] a_q;
	logic [15:0] b_q;
	logic [7:0]  rem_q;
	logic [7:0]  quo_q;
	logic        derr_q;
	logic        carry_q;

	logic [15:0] res_low_q;
	logic [15:0] res_high_q;
	logic        zf_q;
	logic        cf_q;
	logic        of_q;
	logic        de_q;

	logic        in_derr;
	logic [8:0]  trial;
	logic [8:0]  trial_sub;
	logic [15:0] am;
	logic [15:0] bm;
	logic        cin;
	logic        is_sub;
	logic        is_arith;
	logic [16:0] r17;
	logic [15:0] res;
	logic        cy;
	logic        sgn_a;
	logic        sgn_b;
	logic        sgn_r;
	logic        ov;
	logic [31:0] prod;

	logic [15:0] nxt_low;
	logic [15:0] nxt_high;
	logic        nxt_zf;
	logic        nxt_cf;
	logic        nxt_of;
	logic        nxt_de;

	assign stat.in_is_div = (operation == OP_DIV);

	assign in_derr = (operand_b[7:0] == 8'd0) || (operand_a[15:8] >= operand_b[7:0]);

	assign trial     = {rem_q, quo_q[7]};
	assign trial_sub = trial - {1'b0, b_q[7:0]};

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q   <= operation;
			word_q <= word_size;
			a_q    <= operand_a;
			b_q    <= operand_b;
			derr_q <= in_derr;
			rem_q  <= operand_a[15:8];
			quo_q  <= operand_a[7:0];
		end else if (cmd.div_step) begin
			if (trial >= {1'b0, b_q[7:0]}) begin
				rem_q <= trial_sub[7:0];
				quo_q <= {quo_q[6:0], 1'b1};
			end else begin
				rem_q <= trial[7:0];
				quo_q <= {quo_q[6:0], 1'b0};
			end
		end
	end

	assign am       = word_q ? a_q : {8'd0, a_q[7:0]};
	assign bm       = word_q ? b_q : {8'd0, b_q[7:0]};
	assign is_sub   = (op_q == OP_SUB) || (op_q == OP_SBB);
	assign is_arith = (op_q == OP_ADD) || (op_q == OP_ADC) || is_sub;
	assign cin      = ((op_q == OP_ADC) || (op_q == OP_SBB)) ? carry_q : 1'b0;
	assign r17      = is_sub ? ({1'b0, am} - {1'b0, bm} - {16'd0, cin})
	                         : ({1'b0, am} + {1'b0, bm} + {16'd0, cin});
	assign res      = word_q ? r17[15:0] : {8'd0, r17[7:0]};
	assign cy       = word_q ? r17[16] : r17[8];
	assign sgn_a    = word_q ? am[15] : am[7];
	assign sgn_b    = word_q ? bm[15] : bm[7];
	assign sgn_r    = word_q ? res[15] : res[7];
	assign ov       = is_sub ? ((sgn_a ^ sgn_b) & (sgn_a ^ sgn_r))
	                         : (~(sgn_a ^ sgn_b) & (sgn_a ^ sgn_r));
	assign prod     = am * bm;

	always_comb begin
		nxt_low  = 16'd0;
		nxt_high = 16'd0;
		nxt_zf   = 1'b0;
		nxt_cf   = 1'b0;
		nxt_of   = 1'b0;
		nxt_de   = 1'b0;
		unique case (op_q)
			OP_ADD, OP_ADC, OP_SUB, OP_SBB: begin
				nxt_low = res;
				nxt_zf  = (res == 16'd0);
				nxt_cf  = cy;
				nxt_of  = ov;
			end
			OP_MUL: begin
				nxt_low  = prod[15:0];
				nxt_high = prod[31:16];
			end
			OP_DIV: begin
				if (derr_q) begin
					nxt_de = 1'b1;
				end else begin
					nxt_low = {rem_q, quo_q};
				end
			end
			default: begin
				nxt_low = 16'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= 1'b0;
		end else if (cmd.load_out && is_arith) begin
			carry_q <= cy;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res_low_q  <= nxt_low;
			res_high_q <= nxt_high;
			zf_q       <= nxt_zf;
			cf_q       <= nxt_cf;
			of_q       <= nxt_of;
			de_q       <= nxt_de;
		end
	end

	assign result_low    = res_low_q;
	assign result_high   = res_high_q;
	assign zero_flag     = zf_q;
	assign carry_flag    = cf_q;
	assign overflow_flag = of_q;
	assign divide_error  = de_q;

endmodule

FILE: design/x86au_ctrl.sv
// x86au_ctrl: sequencer for operand capture, divide steps and result
// transfer. Depends on x86au_pkg.
`timescale 1ns / 1ps

module x86au_ctrl
	import x86au_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  x86au_stat_t stat,
	output x86au_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	localparam int CW = $clog2(DIV_STEPS);
	localparam logic [CW-1:0] CNT_LAST = CW'(DIV_STEPS - 1);

	logic [1:0]    state_q;
	logic [1:0]    state_d;
	logic [CW-1:0] cnt_q;
	logic          out_valid_q;
	logic          slot_free;
	logic          accept;
	logic          finish;
	logic [1:0]    start_st;

	assign slot_free = !out_valid_q || out_ready;
	assign finish    = (state_q == ST_HOLD) && slot_free;
	assign in_ready  = (state_q == ST_IDLE) || finish;
	assign accept    = in_valid && in_ready;
	assign start_st  = stat.in_is_div ? ST_DIV : ST_HOLD;

	assign cmd.load_in  = accept;
	assign cmd.div_step = (state_q == ST_DIV);
	assign cmd.load_out = finish;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = start_st;
			end
			ST_DIV: begin
				if (cnt_q == CNT_LAST) state_d = ST_HOLD;
			end
			ST_HOLD: begin
				if (finish) state_d = accept ? start_st : ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= '0;
			end else if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_no_accept_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> !in_ready)
		else $error("input taken during divide");

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == CNT_LAST) |=> (state_q == ST_HOLD))
		else $error("divide did not finish after last step");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("result loaded but not presented");

	a_hold_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HOLD && !slot_free) |=> (state_q == ST_HOLD))
		else $error("pending result dropped");

endmodule

FILE: design/x86_sixteen_bit_arith_unit.sv
// Channel | Handshake           | Payload
// input   | in_valid / in_ready | operation, word_size, operand_a, operand_b
// output  | out_valid/out_ready | result_low, result_high, flags, divide_error
//
// Add, subtract and multiply load the result register from the hold state.
// Divide runs 8 restoring steps, one quotient bit each, then the result load.
// A held result does not block the next input transfer; a new result waits
// while the output register is full and out_ready is low.
// arst_n clears the sequencer, output valid and the stored carry.
// Depends on x86au_pkg, x86au_ctrl, x86au_dpath.
`timescale 1ns / 1ps

module x86_sixteen_bit_arith_unit
	import x86au_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  operation,
	input  logic        word_size,
	input  logic [15:0] operand_a,
	input  logic [15:0] operand_b,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] result_low,
	output logic [15:0] result_high,
	output logic        zero_flag,
	output logic        carry_flag,
	output logic        overflow_flag,
	output logic        divide_error
);

	x86au_cmd_t  cmd;
	x86au_stat_t stat;

	x86au_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	x86au_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.operation     (operation),
		.word_size     (word_size),
		.operand_a     (operand_a),
		.operand_b     (operand_b),
		.result_low    (result_low),
		.result_high   (result_high),
		.zero_flag     (zero_flag),
		.carry_flag    (carry_flag),
		.overflow_flag (overflow_flag),
		.divide_error  (divide_error)
	);

endmodule
